[rtl/core/riscv_instruction_encoder_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the instruction encoder
// Shorthand for clocked properties that are disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef RISCV_INSTRUCTION_ENCODER_ASSERT_SVH
`define RISCV_INSTRUCTION_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RVIE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("encoder check failed");

// Implication whose consequent starts in the cycle after the antecedent.
`define RVIE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("encoder check failed");

`endif

[rtl/core/rvie_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Instruction encoder package
// Transfer types, opcode table and error codes of the instruction encoder.
// ---------------------------------------------------------------------------
package rvie_pkg;

    typedef enum logic [2:0] {
        FMT_R,
        FMT_I,
        FMT_S,
        FMT_SB,
        FMT_U,
        FMT_UJ
    } t_fmt;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_IMM   = 3'd1,
        ERR_OFS   = 3'd2,
        ERR_LABEL = 3'd3,
        ERR_MNEM  = 3'd4
    } t_err;

    // Mnemonic ids, in table order; the last value marks an unknown mnemonic.
    typedef enum logic [4:0] {
        MN_ADD, MN_SUB, MN_SLL, MN_SLT, MN_SRA, MN_SRL, MN_AND, MN_OR,
        MN_XOR, MN_MUL, MN_DIV, MN_REM, MN_ADDI, MN_ANDI, MN_ORI, MN_JALR,
        MN_LB, MN_LH, MN_LW, MN_LD, MN_SB, MN_SH, MN_SW, MN_SD,
        MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_LUI, MN_AUIPC, MN_JAL,
        MN_UNKNOWN = 5'd31
    } t_mnemonic;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULT = 7'h01;

    // The one value that passes the sign check on bits 31..20 but still lies
    // above the U immediate bound, so it is rejected on its own.
    localparam logic [31:0] U_IMM_EXCLUDED = 32'h000F_FFFF;

    typedef struct packed {
        logic [4:0]         func;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic signed [31:0] imm;
        logic [31:0]        target_addr;
        logic               label_found;
        logic [31:0]        pc;
    } t_enc_in;

    typedef struct packed {
        logic [31:0] machine_word;
        logic [2:0]  error_code;
    } t_enc_out;

    typedef struct packed {
        logic       known;
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
        t_fmt       fmt;
    } t_op_entry;

    function automatic t_op_entry rvie_lookup(input logic [4:0] func);
        t_op_entry e;
        e = '{known: 1'b1, opc: OPC_OP, f3: 3'd0, f7: F7_BASE, fmt: FMT_R};
        unique case (t_mnemonic'(func))
            MN_ADD:   e = '{1'b1, OPC_OP,     3'd0, F7_BASE, FMT_R};
            MN_SUB:   e = '{1'b1, OPC_OP,     3'd0, F7_ALT,  FMT_R};
            MN_SLL:   e = '{1'b1, OPC_OP,     3'd1, F7_BASE, FMT_R};
            MN_SLT:   e = '{1'b1, OPC_OP,     3'd2, F7_BASE, FMT_R};
            MN_SRA:   e = '{1'b1, OPC_OP,     3'd5, F7_ALT,  FMT_R};
            MN_SRL:   e = '{1'b1, OPC_OP,     3'd5, F7_BASE, FMT_R};
            MN_AND:   e = '{1'b1, OPC_OP,     3'd7, F7_BASE, FMT_R};
            MN_OR:    e = '{1'b1, OPC_OP,     3'd6, F7_BASE, FMT_R};
            MN_XOR:   e = '{1'b1, OPC_OP,     3'd4, F7_BASE, FMT_R};
            MN_MUL:   e = '{1'b1, OPC_OP,     3'd0, F7_MULT, FMT_R};
            MN_DIV:   e = '{1'b1, OPC_OP,     3'd4, F7_MULT, FMT_R};
            MN_REM:   e = '{1'b1, OPC_OP,     3'd6, F7_MULT, FMT_R};
            MN_ADDI:  e = '{1'b1, OPC_OP_IMM, 3'd0, F7_BASE, FMT_I};
            MN_ANDI:  e = '{1'b1, OPC_OP_IMM, 3'd7, F7_BASE, FMT_I};
            MN_ORI:   e = '{1'b1, OPC_OP_IMM, 3'd6, F7_BASE, FMT_I};
            MN_JALR:  e = '{1'b1, OPC_JALR,   3'd0, F7_BASE, FMT_I};
            MN_LB:    e = '{1'b1, OPC_LOAD,   3'd0, F7_BASE, FMT_I};
            MN_LH:    e = '{1'b1, OPC_LOAD,   3'd1, F7_BASE, FMT_I};
            MN_LW:    e = '{1'b1, OPC_LOAD,   3'd2, F7_BASE, FMT_I};
            MN_LD:    e = '{1'b1, OPC_LOAD,   3'd3, F7_BASE, FMT_I};
            MN_SB:    e = '{1'b1, OPC_STORE,  3'd0, F7_BASE, FMT_S};
            MN_SH:    e = '{1'b1, OPC_STORE,  3'd1, F7_BASE, FMT_S};
            MN_SW:    e = '{1'b1, OPC_STORE,  3'd2, F7_BASE, FMT_S};
            MN_SD:    e = '{1'b1, OPC_STORE,  3'd3, F7_BASE, FMT_S};
            MN_BEQ:   e = '{1'b1, OPC_BRANCH, 3'd0, F7_BASE, FMT_SB};
            MN_BNE:   e = '{1'b1, OPC_BRANCH, 3'd1, F7_BASE, FMT_SB};
            MN_BLT:   e = '{1'b1, OPC_BRANCH, 3'd4, F7_BASE, FMT_SB};
            MN_BGE:   e = '{1'b1, OPC_BRANCH, 3'd5, F7_BASE, FMT_SB};
            MN_LUI:   e = '{1'b1, OPC_LUI,    3'd0, F7_BASE, FMT_U};
            MN_AUIPC: e = '{1'b1, OPC_AUIPC,  3'd0, F7_BASE, FMT_U};
            MN_JAL:   e = '{1'b1, OPC_JAL,    3'd0, F7_BASE, FMT_UJ};
            default:  e = '{1'b0, OPC_OP,     3'd0, F7_BASE, FMT_R};
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

[rtl/core/riscv_instruction_encoder.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// RISC-V instruction encoder
// Packs one resolved instruction into a 32-bit machine word with error check.
// ---------------------------------------------------------------------------
// Usage:
// An instruction is transferred in at a rising clock edge where start is high
// and busy is low. The payload i_item carries the mnemonic id, register
// numbers, immediate, label address, label-found flag and instruction address.
// The block registers the instruction, looks up the opcode table, forms the
// branch or jump offset with one 32-bit subtraction, checks ranges and packs
// the word, all in combinational logic, then registers the result.
// A result appears with o_strobe high for exactly one cycle, once its input
// has passed the input and output registers. Throughput is one instruction
// per cycle while busy is low; the table lookup and offset subtraction set the
// critical path. There is no output stall: the receiver must take each result
// in the cycle it is strobed, so no backpressure path exists.
// Synchronous active-low reset drops both valid flags and holds busy high
// until the first edge after reset is released; no transfer is taken during
// reset. On any error the word is zero and error_code says why.
// ---------------------------------------------------------------------------
module riscv_instruction_encoder
    import rvie_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_enc_in  i_item,
    output logic          o_strobe,
    output t_enc_out      o_result
);

    // Set at the first edge after reset is released; gates input transfers.
    logic     r_up;
    logic     r_in_vld;
    t_enc_in  r_in;
    logic     r_out_vld;
    t_enc_out r_out;

    t_op_entry   op;
    logic [31:0] ofs;
    logic [31:0] imm_bits;
    logic        imm12_ok;
    logic        immu_ok;
    logic        sb_ok;
    logic        uj_ok;
    t_enc_out    n_out;

    assign busy = ~r_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up      <= 1'b0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_up      <= 1'b1;
            r_in_vld  <= start & r_up;
            r_out_vld <= r_in_vld;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (start && r_up) begin
            r_in <= i_item;
        end
        r_out <= n_out;
    end

    // Range checks reduce to sign-bit agreement over the upper bits.
    assign op       = rvie_lookup(r_in.func);
    assign ofs      = r_in.target_addr - r_in.pc;
    assign imm_bits = r_in.imm;
    assign imm12_ok = (&imm_bits[31:11]) | ~(|imm_bits[31:11]);
    assign immu_ok  = ((&imm_bits[31:20]) | ~(|imm_bits[31:20]))
                      && (imm_bits != U_IMM_EXCLUDED);
    assign sb_ok    = ~ofs[0] && ((&ofs[31:12]) | ~(|ofs[31:12]));
    assign uj_ok    = ~ofs[0] && ((&ofs[31:20]) | ~(|ofs[31:20]));

    always_comb begin
        n_out.machine_word = '0;
        n_out.error_code   = ERR_OK;
        if (!op.known) begin
            n_out.error_code = ERR_MNEM;
        end else begin
            unique case (op.fmt)
                FMT_R: begin
                    n_out.machine_word = {op.f7, r_in.rs2, r_in.rs1, op.f3,
                                          r_in.rd, op.opc};
                end
                FMT_I: begin
                    if (!imm12_ok) begin
                        n_out.error_code = ERR_IMM;
                    end else begin
                        n_out.machine_word = {imm_bits[11:0], r_in.rs1, op.f3,
                                              r_in.rd, op.opc};
                    end
                end
                FMT_S: begin
                    if (!imm12_ok) begin
                        n_out.error_code = ERR_IMM;
                    end else begin
                        n_out.machine_word = {imm_bits[11:5], r_in.rs2, r_in.rs1,
                                              op.f3, imm_bits[4:0], op.opc};
                    end
                end
                FMT_SB: begin
                    if (!r_in.label_found) begin
                        n_out.error_code = ERR_LABEL;
                    end else if (!sb_ok) begin
                        n_out.error_code = ERR_OFS;
                    end else begin
                        n_out.machine_word = {ofs[12], ofs[10:5], r_in.rs2,
                                              r_in.rs1, op.f3, ofs[4:1], ofs[11],
                                              op.opc};
                    end
                end
                FMT_U: begin
                    if (!immu_ok) begin
                        n_out.error_code = ERR_IMM;
                    end else begin
                        n_out.machine_word = {imm_bits[19:0], r_in.rd, op.opc};
                    end
                end
                FMT_UJ: begin
                    if (!r_in.label_found) begin
                        n_out.error_code = ERR_LABEL;
                    end else if (!uj_ok) begin
                        n_out.error_code = ERR_OFS;
                    end else begin
                        n_out.machine_word = {ofs[20], ofs[10:1], ofs[11],
                                              ofs[19:12], r_in.rd, op.opc};
                    end
                end
                default: begin
                    n_out.error_code = ERR_MNEM;
                end
            endcase
        end
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule
`default_nettype wire

[rtl/core/rvie_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Instruction encoder port checker
// Watches the encoder ports for latency and result consistency.
// ---------------------------------------------------------------------------
`include "riscv_instruction_encoder_assert.svh"

module rvie_checker
    import rvie_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire t_enc_in  i_item,
    input wire logic     o_strobe,
    input wire t_enc_out o_result
);

    logic take;
    logic has_err;
    logic mnem_err;

    assign take     = start && !busy;
    assign has_err  = o_result.error_code != ERR_OK;
    assign mnem_err = o_result.error_code == ERR_MNEM;

    // Every transfer in yields a strobed result after the input and output registers.
    `RVIE_ASSERT_NEXT(a_latency, take, ##1 o_strobe)

    // An unknown mnemonic reports its own error code.
    `RVIE_ASSERT_NEXT(a_unknown, take && (i_item.func == MN_UNKNOWN), ##1 (o_strobe && mnem_err))

    // Any error forces the machine word to zero.
    `RVIE_ASSERT_NOW(a_err_zero, o_strobe && has_err, o_result.machine_word == 32'd0)

    // A good word always carries a 32-bit opcode (low bits both set).
    `RVIE_ASSERT_NOW(a_ok_opcode, o_strobe && !has_err, o_result.machine_word[1:0] == 2'b11)

endmodule

bind riscv_instruction_encoder rvie_checker u_rvie_checker (.*);
`default_nettype wire

[tb/tb_riscv_instruction_encoder.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Testbench for the RISC-V instruction encoder
// Sends directed and random instructions through the encoder with random
// gaps between transfers. Each accepted instruction is encoded again by a
// model inside the testbench, and every strobed result is compared, field by
// field, with the oldest expected word.
// ---------------------------------------------------------------------------
module tb_riscv_instruction_encoder
    import rvie_pkg::*;
();

    localparam int RANDOM_INSTRS  = 1500;
    // The last stretch of the run is sent back to back, without gaps.
    localparam int QUIET_TAIL     = 150;
    // Drain after the last result, in which a stray result would still be caught.
    localparam int DRAIN_CYCLES   = 6;
    // Longest correct wait with nothing moving is the longest gap plus the
    // pipeline; this limit is far beyond that.
    localparam int WATCHDOG_LIMIT = 2000;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_enc_in  item_bus = '0;
    logic     busy;
    logic     o_strobe;
    t_enc_out o_result;

    // Instructions still to be sent, and encodings still to be returned.
    t_enc_in  instr_q[$];
    t_enc_out expected_word_q[$];

    int n_instr_total = 0;
    int n_instr_taken = 0;
    int fail_cnt      = 0;
    int stall_cycles  = 0;
    int gap_left      = 0;
    // Set at each rising edge when the instruction on the bus was transferred.
    bit taken_last_edge = 1'b0;

    riscv_instruction_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item_bus),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Encoding model. The mnemonic selects opcode, funct3, funct7 and format;
    // the range checks come before any packing, and any error gives a zero
    // word. Branch and jump offsets wrap at 32 bits and are read as signed.
    // -----------------------------------------------------------------------
    function automatic t_enc_out encode_instr(input t_enc_in x);
        t_enc_out           r;
        logic [6:0]         opc;
        logic [2:0]         f3;
        logic [6:0]         f7;
        t_fmt               fmt;
        logic               known;
        logic [31:0]        ofs;
        logic signed [31:0] sofs;
        logic [31:0]        w;
        t_err               err;
        known = 1'b1;
        opc   = OPC_OP;
        f3    = 3'd0;
        f7    = F7_BASE;
        fmt   = FMT_R;
        case (t_mnemonic'(x.func))
            MN_ADD:   begin f3 = 3'd0; end
            MN_SUB:   begin f3 = 3'd0; f7 = F7_ALT; end
            MN_SLL:   begin f3 = 3'd1; end
            MN_SLT:   begin f3 = 3'd2; end
            MN_SRA:   begin f3 = 3'd5; f7 = F7_ALT; end
            MN_SRL:   begin f3 = 3'd5; end
            MN_AND:   begin f3 = 3'd7; end
            MN_OR:    begin f3 = 3'd6; end
            MN_XOR:   begin f3 = 3'd4; end
            MN_MUL:   begin f3 = 3'd0; f7 = F7_MULT; end
            MN_DIV:   begin f3 = 3'd4; f7 = F7_MULT; end
            MN_REM:   begin f3 = 3'd6; f7 = F7_MULT; end
            MN_ADDI:  begin opc = OPC_OP_IMM; f3 = 3'd0; fmt = FMT_I; end
            MN_ANDI:  begin opc = OPC_OP_IMM; f3 = 3'd7; fmt = FMT_I; end
            MN_ORI:   begin opc = OPC_OP_IMM; f3 = 3'd6; fmt = FMT_I; end
            MN_JALR:  begin opc = OPC_JALR;   f3 = 3'd0; fmt = FMT_I; end
            MN_LB:    begin opc = OPC_LOAD;   f3 = 3'd0; fmt = FMT_I; end
            MN_LH:    begin opc = OPC_LOAD;   f3 = 3'd1; fmt = FMT_I; end
            MN_LW:    begin opc = OPC_LOAD;   f3 = 3'd2; fmt = FMT_I; end
            MN_LD:    begin opc = OPC_LOAD;   f3 = 3'd3; fmt = FMT_I; end
            MN_SB:    begin opc = OPC_STORE;  f3 = 3'd0; fmt = FMT_S; end
            MN_SH:    begin opc = OPC_STORE;  f3 = 3'd1; fmt = FMT_S; end
            MN_SW:    begin opc = OPC_STORE;  f3 = 3'd2; fmt = FMT_S; end
            MN_SD:    begin opc = OPC_STORE;  f3 = 3'd3; fmt = FMT_S; end
            MN_BEQ:   begin opc = OPC_BRANCH; f3 = 3'd0; fmt = FMT_SB; end
            MN_BNE:   begin opc = OPC_BRANCH; f3 = 3'd1; fmt = FMT_SB; end
            MN_BLT:   begin opc = OPC_BRANCH; f3 = 3'd4; fmt = FMT_SB; end
            MN_BGE:   begin opc = OPC_BRANCH; f3 = 3'd5; fmt = FMT_SB; end
            MN_LUI:   begin opc = OPC_LUI;    fmt = FMT_U; end
            MN_AUIPC: begin opc = OPC_AUIPC;  fmt = FMT_U; end
            MN_JAL:   begin opc = OPC_JAL;    fmt = FMT_UJ; end
            default:  begin known = 1'b0; end
        endcase

        ofs  = x.target_addr - x.pc;
        sofs = ofs;
        err  = ERR_OK;
        w    = '0;
        if (!known) begin
            err = ERR_MNEM;
        end else begin
            case (fmt)
                FMT_R: begin
                    w = {f7, x.rs2, x.rs1, f3, x.rd, opc};
                end
                FMT_I: begin
                    if (x.imm < -2048 || x.imm > 2047) err = ERR_IMM;
                    else w = {x.imm[11:0], x.rs1, f3, x.rd, opc};
                end
                FMT_S: begin
                    if (x.imm < -2048 || x.imm > 2047) err = ERR_IMM;
                    else w = {x.imm[11:5], x.rs2, x.rs1, f3, x.imm[4:0], opc};
                end
                FMT_SB: begin
                    // A missing label wins over a bad offset.
                    if (!x.label_found) err = ERR_LABEL;
                    else if (ofs[0] || sofs > 4095 || sofs < -4096) err = ERR_OFS;
                    else w = {ofs[12], ofs[10:5], x.rs2, x.rs1, f3, ofs[4:1],
                              ofs[11], opc};
                end
                FMT_U: begin
                    // The upper bound stops one short of the 20-bit maximum.
                    if (x.imm < -1048576 || x.imm > 1048574) err = ERR_IMM;
                    else w = {x.imm[19:0], x.rd, opc};
                end
                default: begin
                    if (!x.label_found) err = ERR_LABEL;
                    else if (ofs[0] || sofs > 1048575 || sofs < -1048576) err = ERR_OFS;
                    else w = {ofs[20], ofs[10:1], ofs[11], ofs[19:12], x.rd, opc};
                end
            endcase
        end
        if (err != ERR_OK) w = '0;
        r.machine_word = w;
        r.error_code   = err;
        return r;
    endfunction

    task automatic queue_instr(input logic [4:0] func, input logic [4:0] rd,
                               input logic [4:0] rs1, input logic [4:0] rs2,
                               input logic [31:0] imm, input logic [31:0] tgt,
                               input logic found, input logic [31:0] pc);
        t_enc_in x;
        x.func        = func;
        x.rd          = rd;
        x.rs1         = rs1;
        x.rs2         = rs2;
        x.imm         = imm;
        x.target_addr = tgt;
        x.label_found = found;
        x.pc          = pc;
        instr_q = {instr_q, x};
        n_instr_total++;
    endtask

    // -----------------------------------------------------------------------
    // Driver. At each falling edge, once the previous instruction has been
    // transferred (or none is on the bus), it either starts a random gap or
    // puts the next pending instruction on the bus. start stays high across
    // back-to-back transfers and only changes once here per time step. A busy
    // encoder simply holds the instruction in place.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken_last_edge) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (instr_q.size() == 0) begin
                start <= 1'b0;
            end else if (instr_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 3);
                start <= 1'b0;
            end else begin
                item_bus <= instr_q.pop_front();
                start    <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor. At each rising edge it records an input transfer and its
    // expected encoding, then checks a strobed result against the oldest
    // expectation. Values read here are those from before the edge.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_enc_out exp_res;
        taken_last_edge = i_rst_n && start && !busy;
        if (taken_last_edge) begin
            expected_word_q = {expected_word_q, encode_instr(item_bus)};
            n_instr_taken++;
        end
        if (i_rst_n && o_strobe) begin
            if (expected_word_q.size() == 0) begin
                $error("result with no instruction outstanding: word %h, error_code %0d",
                       o_result.machine_word, o_result.error_code);
                fail_cnt++;
            end else begin
                exp_res = expected_word_q.pop_front();
                if (o_result.machine_word !== exp_res.machine_word) begin
                    $error("machine_word: expected %h, got %h",
                           exp_res.machine_word, o_result.machine_word);
                    fail_cnt++;
                end
                if (o_result.error_code !== exp_res.error_code) begin
                    $error("error_code: expected %0d, got %0d",
                           exp_res.error_code, o_result.error_code);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither side has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run.
    // -----------------------------------------------------------------------
    initial begin
        logic [31:0] pc;
        logic [31:0] imm;
        int          ofs;
        int          pick;
        int          k;
        int          imm_edges[10];
        int          ofs_edges[10];
        imm_edges = '{-2049, -2048, 2047, 2048, -1048577, -1048576,
                      1048574, 1048575, 0, -1};
        ofs_edges = '{-4096, 4094, 4096, -4098, -1048576, 1048574,
                      1048576, -1048578, 1, 3};

        // Directed part. Every R-type operation, with all-ones and all-zero
        // register numbers at the ends.
        queue_instr(MN_ADD, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, '1, 1'b1, '1);
        queue_instr(MN_SUB, 5'd0, 5'd0, 5'd0, '0, '0, 1'b0, '0);
        for (k = 2; k < 12; k++)
            queue_instr(5'(k), 5'(k), 5'(31 - k), 5'(k) ^ 5'h15, '0, '0, 1'b0, '0);

        // Immediate forms at both limits, one past them and at the 32-bit ends.
        queue_instr(MN_ADDI, 5'd31, 5'd1,  5'd0, -32'sd2048, '0, 1'b0, 32'h100);
        queue_instr(MN_ANDI, 5'd1,  5'd31, 5'd0, 32'sd2047,  '0, 1'b0, 32'h100);
        queue_instr(MN_ORI,  5'd2,  5'd3,  5'd0, 32'sd2048,  '0, 1'b0, 32'h100);
        queue_instr(MN_JALR, 5'd1,  5'd5,  5'd0, -32'sd2049, '0, 1'b0, 32'h100);
        queue_instr(MN_LB,   5'd4,  5'd2,  5'd0, 32'sd0,     '0, 1'b0, 32'h100);
        queue_instr(MN_LH,   5'd6,  5'd7,  5'd0, 32'hFFFF_FFFF, '0, 1'b0, 32'h100);
        queue_instr(MN_LW,   5'd8,  5'd9,  5'd0, 32'h7FFF_FFFF, '0, 1'b0, 32'h100);
        queue_instr(MN_LD,   5'd10, 5'd11, 5'd0, 32'h8000_0000, '0, 1'b0, 32'h100);
        queue_instr(MN_SB,   5'd0,  5'd31, 5'd31, -32'sd2048, '0, 1'b0, 32'h200);
        queue_instr(MN_SH,   5'd0,  5'd1,  5'd2,  32'sd2047,  '0, 1'b0, 32'h200);
        queue_instr(MN_SW,   5'd0,  5'd3,  5'd4,  32'sd2048,  '0, 1'b0, 32'h200);
        queue_instr(MN_SD,   5'd0,  5'd5,  5'd6,  -32'sd2049, '0, 1'b0, 32'h200);

        // Branches: missing label with an odd offset (label error wins), the
        // offset limits with a wrap through zero, one past, and an odd offset.
        queue_instr(MN_BEQ, 5'd0, 5'd1, 5'd2, '0, 32'h1001, 1'b0, 32'h1000);
        queue_instr(MN_BNE, 5'd0, 5'd31, 5'd31, '0, 32'hFFFF_F800 + 32'd4094, 1'b1,
                    32'hFFFF_F800);
        queue_instr(MN_BLT, 5'd0, 5'd3, 5'd4, '0, 32'h1000 - 32'd4096, 1'b1, 32'h1000);
        queue_instr(MN_BGE, 5'd0, 5'd5, 5'd6, '0, 32'h1000 + 32'd4096, 1'b1, 32'h1000);
        queue_instr(MN_BEQ, 5'd0, 5'd7, 5'd8, '0, 32'h1003, 1'b1, 32'h1000);

        // Upper immediates at their limits and just past the upper one.
        queue_instr(MN_LUI,   5'd31, 5'd0, 5'd0, 32'sd1048574,  '0, 1'b0, 32'h300);
        queue_instr(MN_LUI,   5'd1,  5'd0, 5'd0, -32'sd1048576, '0, 1'b0, 32'h300);
        queue_instr(MN_AUIPC, 5'd2,  5'd0, 5'd0, 32'sd1048575,  '0, 1'b0, 32'h300);

        // Jumps: farthest back, one past forward, and an undefined label.
        queue_instr(MN_JAL, 5'd1, 5'd0, 5'd0, '0, 32'h0010_0000 - 32'd1048576, 1'b1,
                    32'h0010_0000);
        queue_instr(MN_JAL, 5'd1, 5'd0, 5'd0, '0, 32'h0010_0000 + 32'd1048576, 1'b1,
                    32'h0010_0000);
        queue_instr(MN_JAL, 5'd1, 5'd0, 5'd0, '0, 32'h0010_0004, 1'b0, 32'h0010_0000);

        queue_instr(MN_UNKNOWN, 5'd3, 5'd4, 5'd5, '0, '0, 1'b1, '0);

        // Random part. Immediates and offsets are drawn mostly from the
        // legal ranges so that most words get packed, with the edges and
        // fully random values mixed in to reach every error and every bit.
        for (k = 0; k < RANDOM_INSTRS; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)      imm = 32'(int'($urandom_range(0, 4095)) - 2048);
            else if (pick < 7) imm = 32'(int'($urandom_range(0, 2097150)) - 1048576);
            else if (pick < 9) imm = 32'(imm_edges[$urandom_range(0, 9)]);
            else               imm = $urandom;

            pick = $urandom_range(0, 9);
            if (pick < 4)      ofs = (int'($urandom_range(0, 4095)) - 2048) * 2;
            else if (pick < 7) ofs = (int'($urandom_range(0, 1048575)) - 524288) * 2;
            else if (pick < 9) ofs = ofs_edges[$urandom_range(0, 9)];
            else               ofs = int'($urandom);

            pc = $urandom;
            queue_instr(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                        5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                        imm, pc + 32'(ofs), $urandom_range(0, 9) != 0, pc);
        end

        // Reset is released at a falling edge, away from the rising edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transfer, then for every result, then a short drain
        // in which any stray result would still be caught.
        wait (n_instr_taken == n_instr_total);
        while (expected_word_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
